// ===== design/egcd_pkg.sv =====
// Shared types for the extended GCD block: controller states and command/status bundles.
package egcd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_STEP = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic swap;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic b_zero;
    logic div_last;
    logic rem_zero;
  } sts_t;

endpackage

// ===== design/egcd_ctrl.sv =====
// Controller state machine of the extended GCD block: sequences load, division, swap and result write.
module egcd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  egcd_pkg::sts_t  sts,
  output egcd_pkg::cmd_t  cmd
);

  egcd_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      egcd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.b_zero ? egcd_pkg::ST_FIN : egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = egcd_pkg::ST_STEP;
        end
      end
      egcd_pkg::ST_STEP: begin
        if (sts.rem_zero) begin
          state_nxt = egcd_pkg::ST_FIN;
        end else begin
          cmd.swap  = 1'b1;
          state_nxt = egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.write = 1'b1;
          state_nxt = egcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.write) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== design/egcd_dp.sv =====
// Datapath of the extended GCD block: bit-serial divider, coefficient accumulators and result register.
module egcd_dp #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  egcd_pkg::cmd_t             cmd,
  output egcd_pkg::sts_t             sts,
  input  logic [OPERAND_WIDTH-1:0]   operand_a,
  input  logic [OPERAND_WIDTH-1:0]   operand_b,
  output logic [OPERAND_WIDTH-1:0]   divisor,
  output logic [OPERAND_WIDTH:0]     coeff_a,
  output logic [OPERAND_WIDTH:0]     coeff_b,
  output logic                       zero_divisor_error
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CW    = OPERAND_WIDTH + 1;
  localparam int CNT_W = $clog2(OPERAND_WIDTH);

  logic [W-1:0]     quo_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     den_r;
  logic [CW-1:0]    s0_r, s1_r, t0_r, t1_r;
  logic [CW-1:0]    acc_s_r, acc_t_r;
  logic [CNT_W-1:0] cnt_r;
  logic             err_r;

  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;
  logic [W-1:0]     rem_nxt;
  logic [CW-1:0]    acc_s_nxt, acc_t_nxt;

  assign trial     = {rem_r, quo_r[W-1]};
  assign diff      = trial - {1'b0, den_r};
  assign ge        = trial >= {1'b0, den_r};
  assign rem_nxt   = ge ? diff[W-1:0] : trial[W-1:0];
  assign acc_s_nxt = {acc_s_r[CW-2:0], 1'b0} + (ge ? s1_r : '0);
  assign acc_t_nxt = {acc_t_r[CW-2:0], 1'b0} + (ge ? t1_r : '0);

  assign sts.b_zero   = (operand_b == '0);
  assign sts.div_last = (cnt_r == CNT_W'(W - 1));
  assign sts.rem_zero = (rem_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load || cmd.swap) begin
      cnt_r <= '0;
    end else if (cmd.div) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r   <= operand_a;
      rem_r   <= '0;
      den_r   <= operand_b;
      s0_r    <= CW'(1);
      s1_r    <= '0;
      t0_r    <= '0;
      t1_r    <= CW'(1);
      acc_s_r <= '0;
      acc_t_r <= '0;
      err_r   <= (operand_b == '0);
    end else if (cmd.div) begin
      quo_r   <= {quo_r[W-2:0], 1'b0};
      rem_r   <= rem_nxt;
      acc_s_r <= acc_s_nxt;
      acc_t_r <= acc_t_nxt;
    end else if (cmd.swap) begin
      quo_r   <= den_r;
      den_r   <= rem_r;
      rem_r   <= '0;
      s0_r    <= s1_r;
      s1_r    <= s0_r - acc_s_r;
      t0_r    <= t1_r;
      t1_r    <= t0_r - acc_t_r;
      acc_s_r <= '0;
      acc_t_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      divisor            <= err_r ? '0 : den_r;
      coeff_a            <= err_r ? '0 : s1_r;
      coeff_b            <= err_r ? '0 : t1_r;
      zero_divisor_error <= err_r;
    end
  end

endmodule

// ===== design/extended_gcd_top.sv =====
// Extended GCD block top level: stream ports around the controller and datapath.
// Each Euclid step runs one bit-serial division, one quotient bit per cycle, with the coefficient
// products built alongside it; one item is in work at a time until its result is written.
// A zero operand_b skips the division and goes straight to the result write, error flag set.
// Synchronous active-low reset clears the state machine and the output valid.
module extended_gcd_top #(
  parameter  int OPERAND_WIDTH = 32,
  localparam int IN_TW         = ((2 * OPERAND_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW        = ((3 * OPERAND_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // operand_a, operand_b
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // divisor, coeff_a, coeff_b
  output logic              out_tuser   // zero_divisor_error
);

  localparam int W = OPERAND_WIDTH;

  egcd_pkg::cmd_t cmd;
  egcd_pkg::sts_t sts;
  logic [W-1:0]   divisor;
  logic [W:0]     coeff_a;
  logic [W:0]     coeff_b;

  egcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  egcd_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .operand_a          (in_tdata[W-1:0]),
    .operand_b          (in_tdata[2*W-1:W]),
    .divisor            (divisor),
    .coeff_a            (coeff_a),
    .coeff_b            (coeff_b),
    .zero_divisor_error (out_tuser)
  );

  assign out_tdata = OUT_TW'({coeff_b, coeff_a, divisor});

endmodule

// ===== design/egcd_chk.sv =====
// Port-level checker for the extended GCD block, bound to the top level.
module egcd_chk #(
  parameter  int OPERAND_WIDTH = 32,
  localparam int IN_TW         = ((2 * OPERAND_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW        = ((3 * OPERAND_WIDTH + 2 + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_TW-1:0]  in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata,
  input logic              out_tuser
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted beat");

  a_zero_b_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH] == '0 && !out_tvalid
    |=> ##1 out_tvalid && out_tuser)
    else $error("zero operand_b did not give an error result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the block");

endmodule

bind extended_gcd_top egcd_chk #(
  .OPERAND_WIDTH (OPERAND_WIDTH)
) u_egcd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
